### rtl/trz_pkg.sv
// Shared types and constants of the triangle rasterizer with depth buffer.
// No dependencies; every other file refers to it by scoped names.
package trz_pkg;

	localparam int CoordW   = 12;
	localparam int ZinW     = 32;
	localparam int ColorW   = 32;
	localparam int DepthW   = 33;
	localparam int CountW   = 13;
	localparam int EdgeW    = 14;
	localparam int WeightW  = 28;
	localparam int AreaW    = 26;
	localparam int AccW     = 64;
	localparam int DivisorW = 33;

	localparam logic [1:0] OpClear    = 2'd0;
	localparam logic [1:0] OpTriangle = 2'd1;
	localparam logic [1:0] OpRead     = 2'd2;

	localparam logic [DepthW-1:0] FarDepth = '1;
	localparam logic [CountW-1:0] CountMax = '1;
	localparam logic [AccW-1:0]   RecipNum = 64'h0000_0001_0000_0000;

	typedef struct packed {
		logic                start;
		logic                is_div;
		logic [AccW-1:0]     opa;
		logic [DivisorW-1:0] opb;
	} alu_req_t;

	typedef struct packed {
		logic                busy;
		logic                done;
		logic [AccW-1:0]     quo;
		logic [DivisorW-1:0] rem;
	} alu_rsp_t;

	typedef enum logic [11:0] {
		StIdle     = 12'b0000_0000_0001,
		StClear    = 12'b0000_0000_0010,
		StRead     = 12'b0000_0000_0100,
		StReadWait = 12'b0000_0000_1000,
		StArea     = 12'b0000_0001_0000,
		StW0       = 12'b0000_0010_0000,
		StRecip    = 12'b0000_0100_0000,
		StMac      = 12'b0000_1000_0000,
		StSdiv     = 12'b0001_0000_0000,
		StWalk     = 12'b0010_0000_0000,
		StDrain    = 12'b0100_0000_0000,
		StResp     = 12'b1000_0000_0000
	} state_t;

endpackage

### rtl/trz_if.sv
// Valid/ready channel interfaces for command items and result items.
// Widths come from trz_pkg.
interface trz_in_if;
	logic                                valid;
	logic                                ready;
	logic [1:0]                          operation;
	logic signed [trz_pkg::CoordW-1:0]   vx1;
	logic signed [trz_pkg::CoordW-1:0]   vy1;
	logic [trz_pkg::ZinW-1:0]            vz1;
	logic signed [trz_pkg::CoordW-1:0]   vx2;
	logic signed [trz_pkg::CoordW-1:0]   vy2;
	logic [trz_pkg::ZinW-1:0]            vz2;
	logic signed [trz_pkg::CoordW-1:0]   vx3;
	logic signed [trz_pkg::CoordW-1:0]   vy3;
	logic [trz_pkg::ZinW-1:0]            vz3;
	logic [trz_pkg::ColorW-1:0]          fill_color;

	modport source(output valid, operation, vx1, vy1, vz1, vx2, vy2, vz2, vx3, vy3, vz3,
		fill_color, input ready);
	modport sink(input valid, operation, vx1, vy1, vz1, vx2, vy2, vz2, vx3, vy3, vz3,
		fill_color, output ready);
endinterface

interface trz_out_if;
	logic                         valid;
	logic                         ready;
	logic [trz_pkg::ColorW-1:0]   pixel_color;
	logic [trz_pkg::DepthW-1:0]   pixel_depth;
	logic [trz_pkg::CountW-1:0]   pixels_written;

	modport source(output valid, pixel_color, pixel_depth, pixels_written, input ready);
	modport sink(input valid, pixel_color, pixel_depth, pixels_written, output ready);
endinterface

### rtl/trz_alu.sv
// Shared multi-cycle arithmetic unit: shift-add multiply and restoring floor divide.
// Depends on trz_pkg for the request and response structs.
module trz_alu (
	input  logic              clk,
	input  logic              arst_n,
	input  trz_pkg::alu_req_t req,
	output trz_pkg::alu_rsp_t rsp
);

	logic [6:0]                      cnt_q;
	logic                            busy_q;
	logic                            div_q;
	logic                            neg_q;
	logic [trz_pkg::AccW-1:0]        acc_q;
	logic [trz_pkg::AccW-1:0]        mcand_q;
	logic [trz_pkg::DivisorW-1:0]    mplier_q;
	logic [trz_pkg::DivisorW-1:0]    rem_q;
	logic [trz_pkg::DivisorW-1:0]    dvs_q;
	logic [trz_pkg::DivisorW:0]      trial;
	logic [trz_pkg::DivisorW:0]      diff;
	logic                            fits;
	logic                            fix;

	always_comb begin
		trial = {rem_q, acc_q[trz_pkg::AccW-1]};
		diff  = trial - {1'b0, dvs_q};
		fits  = trial >= {1'b0, dvs_q};
		fix   = div_q && neg_q && (rem_q != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			cnt_q    <= '0;
			div_q    <= 1'b0;
			neg_q    <= 1'b0;
			acc_q    <= '0;
			mcand_q  <= '0;
			mplier_q <= '0;
			rem_q    <= '0;
			dvs_q    <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			div_q  <= req.is_div;
			rem_q  <= '0;
			if (req.is_div) begin
				cnt_q <= 7'd64;
				neg_q <= req.opa[trz_pkg::AccW-1];
				acc_q <= req.opa[trz_pkg::AccW-1] ? -req.opa : req.opa;
				dvs_q <= req.opb;
			end else begin
				cnt_q    <= 7'd33;
				neg_q    <= 1'b0;
				acc_q    <= '0;
				mcand_q  <= req.opa;
				mplier_q <= req.opb;
			end
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 7'd1;
				if (div_q) begin
					rem_q <= fits ? diff[trz_pkg::DivisorW-1:0] : trial[trz_pkg::DivisorW-1:0];
					acc_q <= {acc_q[trz_pkg::AccW-2:0], fits};
				end else begin
					if (mplier_q[0]) begin
						acc_q <= acc_q + mcand_q;
					end
					mcand_q  <= {mcand_q[trz_pkg::AccW-2:0], 1'b0};
					mplier_q <= {1'b0, mplier_q[trz_pkg::DivisorW-1:1]};
				end
			end
		end
	end

	always_comb begin
		rsp.busy = busy_q;
		rsp.done = busy_q && (cnt_q == '0);
		if (div_q && neg_q) begin
			rsp.quo = fix ? ~acc_q : -acc_q;
		end else begin
			rsp.quo = acc_q;
		end
		rsp.rem = fix ? (dvs_q - rem_q) : rem_q;
	end

endmodule

### rtl/trz_fb.sv
// Frame buffer: color and depth memories, one write and one registered read per cycle.
// Depends on trz_pkg for the data widths.
module trz_fb #(
	parameter int Depth = 4096,
	parameter int AddrW = 12
) (
	input  logic                        clk,
	input  logic                        rd_en,
	input  logic [AddrW-1:0]            rd_addr,
	output logic [trz_pkg::ColorW-1:0]  rd_color,
	output logic [trz_pkg::DepthW-1:0]  rd_depth,
	input  logic                        wr_en,
	input  logic [AddrW-1:0]            wr_addr,
	input  logic [trz_pkg::ColorW-1:0]  wr_color,
	input  logic [trz_pkg::DepthW-1:0]  wr_depth
);

	logic [trz_pkg::ColorW-1:0] color_mem [Depth];
	logic [trz_pkg::DepthW-1:0] depth_mem [Depth];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			color_mem[wr_addr] <= wr_color;
			depth_mem[wr_addr] <= wr_depth;
		end
		if (rd_en) begin
			rd_color <= color_mem[rd_addr];
			rd_depth <= depth_mem[rd_addr];
		end
	end

endmodule

### rtl/triangle_raster_zbuffer.sv
// Triangle rasterizer with depth buffer: sequencer, edge walk and result register.
// Depends on trz_pkg, trz_if, trz_alu and trz_fb.
// A clear writes all SCREEN_WIDTH*SCREEN_HEIGHT pixels; a zero-area triangle goes straight to
// the result; any other triangle runs its setup on the shared divider and multiplier, then
// walks every pixel of its clamped bounding box. One item is worked on at a time; the next
// is taken in the cycle after the result is loaded, which waits while an earlier result is held.
// Reset clears control state and the clear color; the frame buffer is undefined until a clear.
module triangle_raster_zbuffer #(
	parameter int SCREEN_WIDTH  = 64,
	parameter int SCREEN_HEIGHT = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [trz_pkg::ColorW-1:0] cfg_wdata,
	trz_in_if.sink                     cmd,
	trz_out_if.source                  rsp
);

	localparam int PixCount = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int AddrW    = (PixCount > 1) ? $clog2(PixCount) : 1;
	localparam int XW       = (SCREEN_WIDTH > 1) ? $clog2(SCREEN_WIDTH) : 1;
	localparam int YW       = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;
	localparam logic signed [trz_pkg::EdgeW-1:0] XMax = trz_pkg::EdgeW'(SCREEN_WIDTH - 1);
	localparam logic signed [trz_pkg::EdgeW-1:0] YMax = trz_pkg::EdgeW'(SCREEN_HEIGHT - 1);
	localparam logic [AddrW-1:0] RowStep  = AddrW'(SCREEN_WIDTH);
	localparam logic [AddrW-1:0] LastAddr = AddrW'(PixCount - 1);
	localparam int EA [3] = '{1, 2, 0};
	localparam int EB [3] = '{2, 0, 1};

	typedef logic signed [trz_pkg::CoordW-1:0]  coord_t;
	typedef logic signed [trz_pkg::EdgeW-1:0]   edge_t;
	typedef logic signed [trz_pkg::WeightW-1:0] weight_t;
	typedef logic signed [trz_pkg::AccW-1:0]    acc_t;

	trz_pkg::state_t state_q;
	logic [trz_pkg::ColorW-1:0] clear_color_q;
	coord_t vx_q [3];
	coord_t vy_q [3];
	logic [trz_pkg::ZinW-1:0]   vz_q [3];
	logic [trz_pkg::ColorW-1:0] color_q;
	logic [XW-1:0] x0_q, xe_q, x_q;
	logic [YW-1:0] y0_q, ye_q, y_q;
	logic [trz_pkg::AreaW-1:0] abs_area_q;
	edge_t   ex_q [3];
	edge_t   ey_q [3];
	weight_t wrow_q [3];
	weight_t w_q [3];
	logic [trz_pkg::DivisorW-1:0] recip_q [3];
	acc_t sacc_q [3];
	acc_t qx_q, qy_q, qrow_q, q_q;
	logic [trz_pkg::AreaW-1:0] rx_q, ry_q, rrow_q, r_q;
	logic [AddrW-1:0] idx_q, idx_row_q, clr_q;
	logic [1:0] vtx_q, grp_q;
	logic issue_q;
	logic v_s1;
	logic [AddrW-1:0] idx_s1;
	logic [trz_pkg::DepthW-1:0] depth_s1;
	logic [trz_pkg::CountW-1:0] count_q;
	logic [trz_pkg::ColorW-1:0] res_color_q;
	logic [trz_pkg::DepthW-1:0] res_depth_q;
	logic out_vld_q;
	logic [trz_pkg::ColorW-1:0] out_color_q;
	logic [trz_pkg::DepthW-1:0] out_depth_q;
	logic [trz_pkg::CountW-1:0] out_count_q;

	trz_pkg::alu_req_t alu_req;
	trz_pkg::alu_rsp_t alu_rsp;

	logic fb_rd_en, fb_we;
	logic [AddrW-1:0] fb_rd_addr, fb_wr_addr;
	logic [trz_pkg::ColorW-1:0] fb_rd_color, fb_wr_color;
	logic [trz_pkg::DepthW-1:0] fb_rd_depth, fb_wr_depth;

	logic signed [trz_pkg::WeightW-1:0] area;
	edge_t d21x, d21y, d31x, d31y;
	edge_t ex_n [3];
	edge_t ey_n [3];
	weight_t w0_n [3];
	edge_t x0_ext, y0_ext;
	coord_t mnx, mxx, mny, mxy;
	logic [trz_pkg::CoordW-1:0] cx0, cxe, cy0, cye;
	logic covered, rd_in_range, hit, last_x, last_y;
	logic [trz_pkg::AreaW:0] rsum_x, rsum_y;
	logic carry_x, carry_y;
	logic [trz_pkg::AreaW-1:0] rnx, rny;
	acc_t qnx, qny;
	weight_t mac_sel;
	logic resp_load;

	function automatic edge_t sx(input coord_t v);
		return {{(trz_pkg::EdgeW - trz_pkg::CoordW){v[trz_pkg::CoordW-1]}}, v};
	endfunction

	function automatic coord_t min3(input coord_t a, input coord_t b, input coord_t c);
		coord_t m;
		m = (a < b) ? a : b;
		return (m < c) ? m : c;
	endfunction

	function automatic coord_t max3(input coord_t a, input coord_t b, input coord_t c);
		coord_t m;
		m = (a > b) ? a : b;
		return (m > c) ? m : c;
	endfunction

	function automatic logic [trz_pkg::CoordW-1:0] clamp(input coord_t v, input edge_t hi);
		if (v < 0) begin
			return '0;
		end else if (sx(v) > hi) begin
			return hi[trz_pkg::CoordW-1:0];
		end
		return v;
	endfunction

	trz_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.rsp    (alu_rsp)
	);

	trz_fb #(
		.Depth (PixCount),
		.AddrW (AddrW)
	) u_fb (
		.clk      (clk),
		.rd_en    (fb_rd_en),
		.rd_addr  (fb_rd_addr),
		.rd_color (fb_rd_color),
		.rd_depth (fb_rd_depth),
		.wr_en    (fb_we),
		.wr_addr  (fb_wr_addr),
		.wr_color (fb_wr_color),
		.wr_depth (fb_wr_depth)
	);

	always_comb begin
		d21x = sx(vx_q[1]) - sx(vx_q[0]);
		d21y = sx(vy_q[1]) - sx(vy_q[0]);
		d31x = sx(vx_q[2]) - sx(vx_q[0]);
		d31y = sx(vy_q[2]) - sx(vy_q[0]);
		area = weight_t'(d31x) * weight_t'(d21y) - weight_t'(d31y) * weight_t'(d21x);
		mnx = min3(vx_q[0], vx_q[1], vx_q[2]);
		mxx = max3(vx_q[0], vx_q[1], vx_q[2]);
		mny = min3(vy_q[0], vy_q[1], vy_q[2]);
		mxy = max3(vy_q[0], vy_q[1], vy_q[2]);
		cx0 = clamp(mnx, XMax);
		cxe = clamp(mxx, XMax);
		cy0 = clamp(mny, YMax);
		cye = clamp(mxy, YMax);
		x0_ext = {{(trz_pkg::EdgeW - XW){1'b0}}, x0_q};
		y0_ext = {{(trz_pkg::EdgeW - YW){1'b0}}, y0_q};
		for (int i = 0; i < 3; i++) begin
			ex_n[i] = sx(vy_q[EB[i]]) - sx(vy_q[EA[i]]);
			ey_n[i] = sx(vx_q[EA[i]]) - sx(vx_q[EB[i]]);
			if (area < 0) begin
				ex_n[i] = -ex_n[i];
				ey_n[i] = -ey_n[i];
			end
			w0_n[i] = weight_t'(x0_ext - sx(vx_q[EA[i]])) * weight_t'(ex_q[i])
				+ weight_t'(y0_ext - sx(vy_q[EA[i]])) * weight_t'(ey_q[i]);
		end
	end

	always_comb begin
		covered = (w_q[0] >= 0) && (w_q[1] >= 0) && (w_q[2] >= 0);
		last_x  = x_q == xe_q;
		last_y  = y_q == ye_q;
		rsum_x  = {1'b0, r_q} + {1'b0, rx_q};
		carry_x = rsum_x >= {1'b0, abs_area_q};
		rnx     = carry_x ? trz_pkg::AreaW'(rsum_x - {1'b0, abs_area_q})
			: rsum_x[trz_pkg::AreaW-1:0];
		qnx     = q_q + qx_q + acc_t'(carry_x);
		rsum_y  = {1'b0, rrow_q} + {1'b0, ry_q};
		carry_y = rsum_y >= {1'b0, abs_area_q};
		rny     = carry_y ? trz_pkg::AreaW'(rsum_y - {1'b0, abs_area_q})
			: rsum_y[trz_pkg::AreaW-1:0];
		qny     = qrow_q + qy_q + acc_t'(carry_y);
		rd_in_range = !vx_q[0][trz_pkg::CoordW-1] && (sx(vx_q[0]) <= XMax)
			&& !vy_q[0][trz_pkg::CoordW-1] && (sx(vy_q[0]) <= YMax);
		hit = v_s1 && (depth_s1 < fb_rd_depth);
		resp_load = (state_q == trz_pkg::StResp) && (!out_vld_q || rsp.ready);
	end

	always_comb begin
		case (grp_q)
			2'd0:    mac_sel = wrow_q[vtx_q];
			2'd1:    mac_sel = weight_t'(ex_q[vtx_q]);
			default: mac_sel = weight_t'(ey_q[vtx_q]);
		endcase
		alu_req = '0;
		alu_req.start = issue_q;
		case (state_q)
			trz_pkg::StRecip: begin
				alu_req.is_div = 1'b1;
				alu_req.opa    = trz_pkg::RecipNum;
				alu_req.opb    = (vz_q[vtx_q] == '0) ? trz_pkg::DivisorW'(1) : {1'b0, vz_q[vtx_q]};
			end
			trz_pkg::StMac: begin
				alu_req.opa = trz_pkg::AccW'(acc_t'(mac_sel));
				alu_req.opb = recip_q[vtx_q];
			end
			trz_pkg::StSdiv: begin
				alu_req.is_div = 1'b1;
				alu_req.opa    = sacc_q[grp_q];
				alu_req.opb    = trz_pkg::DivisorW'(abs_area_q);
			end
			default: begin
				alu_req.opa = '0;
			end
		endcase
	end

	always_comb begin
		fb_rd_en   = 1'b0;
		fb_rd_addr = idx_q;
		if (state_q == trz_pkg::StWalk) begin
			fb_rd_en = covered;
		end else if (state_q == trz_pkg::StRead) begin
			fb_rd_en   = rd_in_range;
			fb_rd_addr = AddrW'(AddrW'(vy_q[0][YW-1:0]) * RowStep) + AddrW'(vx_q[0][XW-1:0]);
		end
		if (state_q == trz_pkg::StClear) begin
			fb_we       = 1'b1;
			fb_wr_addr  = clr_q;
			fb_wr_color = clear_color_q;
			fb_wr_depth = trz_pkg::FarDepth;
		end else begin
			fb_we       = hit;
			fb_wr_addr  = idx_s1;
			fb_wr_color = color_q;
			fb_wr_depth = depth_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= trz_pkg::StIdle;
			clear_color_q <= '0;
			vx_q          <= '{default: '0};
			vy_q          <= '{default: '0};
			vz_q          <= '{default: '0};
			color_q       <= '0;
			x0_q <= '0; xe_q <= '0; x_q <= '0;
			y0_q <= '0; ye_q <= '0; y_q <= '0;
			abs_area_q    <= '0;
			ex_q          <= '{default: '0};
			ey_q          <= '{default: '0};
			wrow_q        <= '{default: '0};
			w_q           <= '{default: '0};
			recip_q       <= '{default: '0};
			sacc_q        <= '{default: '0};
			qx_q <= '0; qy_q <= '0; qrow_q <= '0; q_q <= '0;
			rx_q <= '0; ry_q <= '0; rrow_q <= '0; r_q <= '0;
			idx_q <= '0; idx_row_q <= '0; clr_q <= '0;
			vtx_q <= '0; grp_q <= '0;
			issue_q       <= 1'b0;
			v_s1          <= 1'b0;
			idx_s1        <= '0;
			depth_s1      <= '0;
			count_q       <= '0;
			res_color_q   <= '0;
			res_depth_q   <= '0;
			out_vld_q     <= 1'b0;
			out_color_q   <= '0;
			out_depth_q   <= '0;
			out_count_q   <= '0;
		end else begin
			if (cfg_we) begin
				clear_color_q <= cfg_wdata;
			end
			issue_q  <= 1'b0;
			v_s1     <= (state_q == trz_pkg::StWalk) && covered;
			idx_s1   <= idx_q;
			depth_s1 <= q_q[trz_pkg::DepthW-1:0];
			if (hit && (count_q != trz_pkg::CountMax)) begin
				count_q <= count_q + trz_pkg::CountW'(1);
			end
			if (resp_load) begin
				out_vld_q   <= 1'b1;
				out_color_q <= res_color_q;
				out_depth_q <= res_depth_q;
				out_count_q <= count_q;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end

			case (state_q)
				trz_pkg::StIdle: begin
					if (cmd.valid) begin
						vx_q        <= '{cmd.vx1, cmd.vx2, cmd.vx3};
						vy_q        <= '{cmd.vy1, cmd.vy2, cmd.vy3};
						vz_q        <= '{cmd.vz1, cmd.vz2, cmd.vz3};
						color_q     <= cmd.fill_color;
						count_q     <= '0;
						clr_q       <= '0;
						res_color_q <= '0;
						res_depth_q <= '0;
						vtx_q       <= '0;
						grp_q       <= '0;
						case (cmd.operation)
							trz_pkg::OpClear:    state_q <= trz_pkg::StClear;
							trz_pkg::OpTriangle: state_q <= trz_pkg::StArea;
							trz_pkg::OpRead:     state_q <= trz_pkg::StRead;
							default:             state_q <= trz_pkg::StResp;
						endcase
					end
				end
				trz_pkg::StClear: begin
					clr_q <= clr_q + AddrW'(1);
					if (clr_q == LastAddr) begin
						state_q <= trz_pkg::StResp;
					end
				end
				trz_pkg::StRead: begin
					state_q <= rd_in_range ? trz_pkg::StReadWait : trz_pkg::StResp;
				end
				trz_pkg::StReadWait: begin
					res_color_q <= fb_rd_color;
					res_depth_q <= fb_rd_depth;
					state_q     <= trz_pkg::StResp;
				end
				trz_pkg::StArea: begin
					abs_area_q <= trz_pkg::AreaW'((area < 0) ? -area : area);
					ex_q       <= ex_n;
					ey_q       <= ey_n;
					x0_q       <= cx0[XW-1:0];
					xe_q       <= cxe[XW-1:0];
					y0_q       <= cy0[YW-1:0];
					ye_q       <= cye[YW-1:0];
					state_q    <= (area == 0) ? trz_pkg::StResp : trz_pkg::StW0;
				end
				trz_pkg::StW0: begin
					wrow_q    <= w0_n;
					w_q       <= w0_n;
					x_q       <= x0_q;
					y_q       <= y0_q;
					idx_row_q <= AddrW'(AddrW'(y0_q) * RowStep) + AddrW'(x0_q);
					idx_q     <= AddrW'(AddrW'(y0_q) * RowStep) + AddrW'(x0_q);
					issue_q   <= 1'b1;
					state_q   <= trz_pkg::StRecip;
				end
				trz_pkg::StRecip: begin
					if (alu_rsp.done) begin
						recip_q[vtx_q] <= alu_rsp.quo[trz_pkg::DivisorW-1:0];
						issue_q        <= 1'b1;
						if (vtx_q == 2'd2) begin
							vtx_q   <= '0;
							state_q <= trz_pkg::StMac;
						end else begin
							vtx_q <= vtx_q + 2'd1;
						end
					end
				end
				trz_pkg::StMac: begin
					if (alu_rsp.done) begin
						sacc_q[grp_q] <= ((vtx_q == 2'd0) ? acc_t'(0) : sacc_q[grp_q]) + alu_rsp.quo;
						issue_q       <= 1'b1;
						if (vtx_q == 2'd2) begin
							vtx_q <= '0;
							if (grp_q == 2'd2) begin
								grp_q   <= '0;
								state_q <= trz_pkg::StSdiv;
							end else begin
								grp_q <= grp_q + 2'd1;
							end
						end else begin
							vtx_q <= vtx_q + 2'd1;
						end
					end
				end
				trz_pkg::StSdiv: begin
					if (alu_rsp.done) begin
						case (grp_q)
							2'd0: begin
								qrow_q <= alu_rsp.quo;
								q_q    <= alu_rsp.quo;
								rrow_q <= alu_rsp.rem[trz_pkg::AreaW-1:0];
								r_q    <= alu_rsp.rem[trz_pkg::AreaW-1:0];
							end
							2'd1: begin
								qx_q <= alu_rsp.quo;
								rx_q <= alu_rsp.rem[trz_pkg::AreaW-1:0];
							end
							default: begin
								qy_q <= alu_rsp.quo;
								ry_q <= alu_rsp.rem[trz_pkg::AreaW-1:0];
							end
						endcase
						if (grp_q == 2'd2) begin
							grp_q   <= '0;
							state_q <= trz_pkg::StWalk;
						end else begin
							grp_q   <= grp_q + 2'd1;
							issue_q <= 1'b1;
						end
					end
				end
				trz_pkg::StWalk: begin
					if (last_x) begin
						if (last_y) begin
							state_q <= trz_pkg::StDrain;
						end else begin
							y_q       <= y_q + YW'(1);
							x_q       <= x0_q;
							for (int i = 0; i < 3; i++) begin
								wrow_q[i] <= wrow_q[i] + weight_t'(ey_q[i]);
								w_q[i]    <= wrow_q[i] + weight_t'(ey_q[i]);
							end
							qrow_q    <= qny;
							q_q       <= qny;
							rrow_q    <= rny;
							r_q       <= rny;
							idx_row_q <= idx_row_q + RowStep;
							idx_q     <= idx_row_q + RowStep;
						end
					end else begin
						x_q <= x_q + XW'(1);
						for (int i = 0; i < 3; i++) begin
							w_q[i] <= w_q[i] + weight_t'(ex_q[i]);
						end
						q_q   <= qnx;
						r_q   <= rnx;
						idx_q <= idx_q + AddrW'(1);
					end
				end
				trz_pkg::StDrain: begin
					state_q <= trz_pkg::StResp;
				end
				trz_pkg::StResp: begin
					if (resp_load) begin
						state_q <= trz_pkg::StIdle;
					end
				end
				default: begin
					state_q <= trz_pkg::StIdle;
				end
			endcase
		end
	end

	assign cmd.ready          = state_q == trz_pkg::StIdle;
	assign rsp.valid          = out_vld_q;
	assign rsp.pixel_color    = out_color_q;
	assign rsp.pixel_depth    = out_depth_q;
	assign rsp.pixels_written = out_count_q;

`ifndef SYNTHESIS
	a_alu_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		alu_req.start |-> !alu_rsp.busy)
		else $error("Arithmetic unit started while busy.");

	a_fb_write_owner: assert property (@(posedge clk) disable iff (!arst_n)
		fb_we |-> (state_q == trz_pkg::StClear || state_q == trz_pkg::StWalk
			|| state_q == trz_pkg::StDrain))
		else $error("Frame buffer written outside clear or edge walk.");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.ready |=> state_q != trz_pkg::StIdle)
		else $error("Accepted item did not start work.");

	a_pixel_from_walk: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> $past(state_q) == trz_pkg::StWalk)
		else $error("Depth test issued outside the edge walk.");
`endif

endmodule
